// ===== hw/rtl/tif_pkg.sv =====
`default_nettype none
package tif_pkg;

	localparam int AXES_DEF = 6;

	localparam int AXIS_W  = 3;
	localparam int FORCE_W = 24;
	localparam int GAIN_W  = 24;
	localparam int DT_W    = 24;
	localparam int Y_W     = 32;
	localparam int SUM_W   = FORCE_W + 2;

	// shared digit-serial multiplier
	localparam int DIG_W         = 8;
	localparam int B_W           = 32;
	localparam int A_W           = 53;
	localparam int PROD_W        = 86;
	localparam int DIGITS_WIDE   = 4;
	localparam int DIGITS_NARROW = 3;

	// weights and quotient
	localparam int BDT_W  = GAIN_W + DT_W;
	localparam int M4_SH  = 26;
	localparam int M8_SH  = 27;
	localparam int NUM_W  = 86;
	localparam int DEN_W  = 51;
	localparam int Q_W    = 32;
	localparam int QCNT_W = 5;

	localparam logic [DT_W-1:0]       DT_RESET = 24'd16777;
	localparam logic signed [Y_W-1:0] Y_MAX    = 32'sh7FFF_FFFF;
	localparam logic signed [Y_W-1:0] Y_MIN    = 32'sh8000_0000;

	typedef struct packed {
		logic signed [FORCE_W-1:0] x1;
		logic signed [FORCE_W-1:0] x2;
		logic signed [Y_W-1:0]     y1;
		logic signed [Y_W-1:0]     y2;
	} hist_t;

	typedef struct packed {
		logic  en;
		hist_t data;
	} hist_wr_t;

	typedef struct packed {
		logic start;
		logic wide;
	} mac_cmd_t;

	typedef struct packed {
		logic           over;
		logic           neg;
		logic [Q_W-1:0] q;
	} div_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tif_if.sv =====
`default_nettype none
interface tif_in_if import tif_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [AXIS_W-1:0]         axis;
	logic signed [FORCE_W-1:0] force_req;
	logic [GAIN_W-1:0]         mass;
	logic [GAIN_W-1:0]         damping;
	logic [GAIN_W-1:0]         stiffness;
	logic                      restart;

	modport source (output valid, axis, force_req, mass, damping, stiffness, restart,
		input ready);
	modport sink (input valid, axis, force_req, mass, damping, stiffness, restart,
		output ready);
	modport monitor (input valid, ready, axis, force_req, mass, damping, stiffness, restart);
endinterface

interface tif_out_if import tif_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [AXIS_W-1:0]     out_axis;
	logic signed [Y_W-1:0] displacement;
	logic                  divide_error;

	modport source (output valid, out_axis, displacement, divide_error, input ready);
	modport sink (input valid, out_axis, displacement, divide_error, output ready);
	modport monitor (input valid, ready, out_axis, displacement, divide_error);
endinterface
`default_nettype wire

// ===== hw/rtl/tustin_impedance_filter.sv =====
`default_nettype none
// Per-axis second-order impedance filter in bilinear form: one displacement beat
// (signed Q8.24, saturated) per force beat, with two force and two displacement
// samples of history kept for each of AXES axes; restart clears one axis before
// its sample is used, and a zero w1 denominator returns zero with divide_error.
// For each item on a valid axis, 20 digit steps of the shared 53 x 9 bit
// multiply-accumulate unit build t2, B*dt, K*t2 and the numerator, then a
// 32-step restoring quotient loop produces the result.
// A new item is taken as soon as the previous result sits in the output
// register; one item is worked on at a time. The user must write sample_period
// through cfg_we/cfg_wdata only while the block is idle, which is not enforced.
module tustin_impedance_filter import tif_pkg::*; #(
	parameter int AXES = AXES_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [DT_W-1:0] cfg_wdata,
	tif_in_if.sink               sample,
	tif_out_if.source            result
);

	localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MUL  = 7'b0000010,
		S_WGT  = 7'b0000100,
		S_KICK = 7'b0001000,
		S_ABS  = 7'b0010000,
		S_DIV  = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	typedef enum logic [2:0] {
		OP_DTDT = 3'd0,
		OP_BDT  = 3'd1,
		OP_KT2  = 3'd2,
		OP_TS   = 3'd3,
		OP_WY1  = 3'd4,
		OP_WY2  = 3'd5
	} op_t;

	state_t                    state_q;
	op_t                       op_q;
	logic [DT_W-1:0]           period_q;

	logic [AXIS_W-1:0]         axis_q;
	logic                      vld_q;
	logic signed [FORCE_W-1:0] x_q;
	logic signed [FORCE_W-1:0] x1_q;
	logic signed [Y_W-1:0]     y1_q;
	logic signed [Y_W-1:0]     y2_q;
	logic signed [SUM_W-1:0]   s_q;
	logic [GAIN_W-1:0]         mass_q;
	logic [GAIN_W-1:0]         damp_q;
	logic [GAIN_W-1:0]         stiff_q;

	logic [DT_W-1:0]           t2_q;
	logic [BDT_W-1:0]          bdt_q;
	logic [BDT_W-1:0]          kt2_q;
	logic [DEN_W-1:0]          w1_q;
	logic signed [A_W-1:0]     w2_q;
	logic signed [A_W-1:0]     w3_q;
	logic signed [NUM_W-1:0]   num_q;
	logic                      err_q;
	logic signed [Y_W-1:0]     y_q;

	logic                      out_valid_q;
	logic [AXIS_W-1:0]         out_axis_q;
	logic signed [Y_W-1:0]     disp_q;
	logic                      derr_q;

	logic                      accept;
	logic                      vld_in;
	logic                      out_free;
	hist_t                     hrd;
	hist_wr_t                  hwr;
	logic signed [FORCE_W-1:0] x1e;
	logic signed [FORCE_W-1:0] x2e;
	logic signed [SUM_W-1:0]   s_d;

	mac_cmd_t                  mac_cmd;
	op_t                       sel_op;
	logic signed [A_W-1:0]     mac_a;
	logic [B_W-1:0]            mac_b;
	logic                      mac_done;
	logic signed [PROD_W-1:0]  prod;

	logic                      div_start;
	logic                      div_done;
	div_res_t                  div_res;
	logic signed [Y_W-1:0]     y_sat;

	logic [A_W-1:0]            m4;
	logic [A_W-1:0]            m8;
	logic [A_W-1:0]            bdt2;
	logic [A_W-1:0]            kt2;
	logic [A_W-1:0]            w1_sum;

	assign sample.ready = (state_q == S_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign vld_in       = 32'(sample.axis) < AXES;
	assign out_free     = !out_valid_q || result.ready;

	tif_hist #(.AXES(AXES)) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (AXW'(sample.axis)),
		.rd     (hrd),
		.wr_idx (AXW'(axis_q)),
		.wr     (hwr)
	);

	always_comb begin
		x1e = sample.restart ? sample.force_req : hrd.x1;
		x2e = sample.restart ? sample.force_req : hrd.x2;
		s_d = SUM_W'(sample.force_req) + (SUM_W'(x1e) <<< 1) + SUM_W'(x2e);
	end

	always_comb begin
		hwr.en      = (state_q == S_DONE) && out_free && vld_q;
		hwr.data.x1 = x_q;
		hwr.data.x2 = x1_q;
		hwr.data.y1 = y_q;
		hwr.data.y2 = y1_q;
	end

	// op sequencing: start the first product on accept or kick, each next as the previous lands
	always_comb begin
		mac_cmd = '0;
		sel_op  = OP_DTDT;
		if (accept && vld_in) begin
			mac_cmd.start = 1'b1;
		end else if (state_q == S_KICK) begin
			mac_cmd.start = 1'b1;
			sel_op        = OP_WY1;
		end else if (state_q == S_MUL && mac_done) begin
			unique case (op_q)
				OP_DTDT: begin
					mac_cmd.start = 1'b1;
					sel_op        = OP_BDT;
				end
				OP_BDT: begin
					mac_cmd.start = 1'b1;
					sel_op        = OP_KT2;
				end
				OP_KT2: begin
					mac_cmd.start = 1'b1;
					sel_op        = OP_TS;
				end
				OP_WY1: begin
					mac_cmd.start = 1'b1;
					sel_op        = OP_WY2;
				end
				default: begin
					mac_cmd.start = 1'b0;
				end
			endcase
		end
		mac_cmd.wide = (sel_op == OP_WY1) || (sel_op == OP_WY2);

		unique case (sel_op)
			OP_DTDT: begin
				mac_a = $signed({{(A_W-DT_W){1'b0}}, period_q});
				mac_b = {period_q, {DIG_W{1'b0}}};
			end
			OP_BDT: begin
				mac_a = $signed({{(A_W-GAIN_W){1'b0}}, damp_q});
				mac_b = {period_q, {DIG_W{1'b0}}};
			end
			OP_KT2: begin
				mac_a = $signed({{(A_W-GAIN_W){1'b0}}, stiff_q});
				mac_b = {t2_q, {DIG_W{1'b0}}};
			end
			OP_TS: begin
				mac_a = A_W'(s_q);
				mac_b = {t2_q, {DIG_W{1'b0}}};
			end
			OP_WY1: begin
				mac_a = w2_q;
				mac_b = y1_q;
			end
			OP_WY2: begin
				mac_a = w3_q;
				mac_b = y2_q;
			end
			default: begin
				mac_a = '0;
				mac_b = '0;
			end
		endcase
	end

	tif_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.a      (mac_a),
		.b      (mac_b),
		.done   (mac_done),
		.prod   (prod)
	);

	always_comb begin
		m4     = A_W'(mass_q) << M4_SH;
		m8     = A_W'(mass_q) << M8_SH;
		bdt2   = A_W'(bdt_q) << 1;
		kt2    = A_W'(kt2_q);
		w1_sum = m4 + bdt2 + kt2;
	end

	assign div_start = (state_q == S_ABS);

	tif_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (w1_q),
		.done   (div_done),
		.res    (div_res)
	);

	always_comb begin
		if (div_res.neg) begin
			y_sat = (div_res.over || (div_res.q[Q_W-1] && |div_res.q[Q_W-2:0])) ?
				Y_MIN : $signed(-div_res.q);
		end else begin
			y_sat = (div_res.over || div_res.q[Q_W-1]) ? Y_MAX : $signed(div_res.q);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			axis_q  <= sample.axis;
			vld_q   <= vld_in;
			x_q     <= sample.force_req;
			x1_q    <= x1e;
			y1_q    <= sample.restart ? '0 : hrd.y1;
			y2_q    <= sample.restart ? '0 : hrd.y2;
			s_q     <= s_d;
			mass_q  <= sample.mass;
			damp_q  <= sample.damping;
			stiff_q <= sample.stiffness;
			if (!vld_in) begin
				y_q   <= '0;
				err_q <= 1'b0;
			end
		end
		if (state_q == S_MUL && mac_done) begin
			unique case (op_q)
				OP_DTDT: t2_q  <= prod[2*DT_W-1:DT_W];
				OP_BDT:  bdt_q <= prod[BDT_W-1:0];
				OP_KT2:  kt2_q <= prod[BDT_W-1:0];
				OP_TS:   num_q <= prod <<< DT_W;
				OP_WY1, OP_WY2: num_q <= num_q - prod;
				default: num_q <= num_q;
			endcase
		end
		if (state_q == S_WGT) begin
			w1_q  <= w1_sum[DEN_W-1:0];
			w2_q  <= $signed((kt2 << 1) - m8);
			w3_q  <= $signed(kt2 + m4 - bdt2);
			err_q <= (w1_sum == '0);
		end
		if (state_q == S_DIV && div_done) begin
			y_q <= err_q ? '0 : y_sat;
		end
		if (state_q == S_DONE && out_free) begin
			out_axis_q <= axis_q;
			disp_q     <= y_q;
			derr_q     <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_DTDT;
			period_q    <= DT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_wdata;
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= OP_DTDT;
						state_q <= vld_in ? S_MUL : S_DONE;
					end
				end
				S_MUL: begin
					if (mac_done) begin
						unique case (op_q)
							OP_DTDT: op_q <= OP_BDT;
							OP_BDT:  op_q <= OP_KT2;
							OP_KT2:  op_q <= OP_TS;
							OP_TS:   state_q <= S_WGT;
							OP_WY1:  op_q <= OP_WY2;
							OP_WY2:  state_q <= S_ABS;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_WGT: begin
					state_q <= S_KICK;
				end
				S_KICK: begin
					op_q    <= OP_WY1;
					state_q <= S_MUL;
				end
				S_ABS: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result.valid        = out_valid_q;
	assign result.out_axis     = out_axis_q;
	assign result.displacement = disp_q;
	assign result.divide_error = derr_q;

endmodule
`default_nettype wire

// ===== hw/rtl/tif_mac.sv =====
`default_nettype none
module tif_mac import tif_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire mac_cmd_t                 cmd,
	input  wire logic signed [A_W-1:0]    a,
	input  wire logic [B_W-1:0]           b,
	output logic                          done,
	output logic signed [PROD_W-1:0]      prod
);

	logic signed [A_W-1:0]       a_q;
	logic [B_W-1:0]              b_q;
	logic signed [PROD_W-1:0]    acc_q;
	logic [1:0]                  cnt_q;
	logic                        busy_q;
	logic                        done_q;

	logic signed [A_W-1:0]       a_sel;
	logic [B_W-1:0]              b_sel;
	logic [DIG_W-1:0]            dig;
	logic signed [DIG_W:0]       sdig;
	logic signed [A_W+DIG_W:0]   pp;
	logic signed [PROD_W-1:0]    base;
	logic signed [PROD_W-1:0]    acc_d;

	// MSB-first: acc = acc * 2^8 + a * digit, top digit signed for wide ops
	always_comb begin
		a_sel = cmd.start ? a : a_q;
		b_sel = cmd.start ? b : b_q;
		dig   = b_sel[B_W-1 -: DIG_W];
		sdig  = (cmd.start && cmd.wide) ? $signed({dig[DIG_W-1], dig}) : $signed({1'b0, dig});
		pp    = a_sel * sdig;
		base  = cmd.start ? '0 : (acc_q <<< DIG_W);
		acc_d = base + PROD_W'(pp);
	end

	always_ff @(posedge clk) begin
		if (cmd.start || busy_q) begin
			a_q   <= a_sel;
			b_q   <= b_sel << DIG_W;
			acc_q <= acc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				cnt_q  <= cmd.wide ? 2'(DIGITS_WIDE - 1) : 2'(DIGITS_NARROW - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 2'd1;
				if (cnt_q == 2'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule
`default_nettype wire

// ===== hw/rtl/tif_div.sv =====
`default_nettype none
module tif_div import tif_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0]        den,
	output logic                         done,
	output div_res_t                     res
);

	logic [NUM_W-1:0]  mag_q;
	logic [DEN_W-1:0]  rem_q;
	logic [Q_W-1:0]    quo_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              neg_q;
	logic              over_q;
	logic              chk_q;
	logic              run_q;
	logic              done_q;

	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              ge;

	always_comb begin
		trial = {rem_q, quo_q[Q_W-1]};
		diff  = trial - {1'b0, den};
		ge    = trial >= {1'b0, den};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			neg_q <= num[NUM_W-1];
		end
		if (chk_q) begin
			// quotient needs more than Q_W bits when high part >= den
			over_q <= mag_q[NUM_W-1:Q_W] >= (NUM_W-Q_W)'(den);
			rem_q  <= mag_q[Q_W+DEN_W-1:Q_W];
			quo_q  <= mag_q[Q_W-1:0];
		end else if (run_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_q  <= 1'b0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			chk_q  <= start;
			if (chk_q) begin
				run_q <= 1'b1;
				cnt_q <= QCNT_W'(Q_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign res.over = over_q;
	assign res.neg  = neg_q;
	assign res.q    = quo_q;

endmodule
`default_nettype wire

// ===== hw/rtl/tif_hist.sv =====
`default_nettype none
module tif_hist import tif_pkg::*; #(
	parameter  int AXES = AXES_DEF,
	localparam int AXW  = (AXES > 1) ? $clog2(AXES) : 1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [AXW-1:0] rd_idx,
	output hist_t               rd,
	input  wire logic [AXW-1:0] wr_idx,
	input  wire hist_wr_t       wr
);

	hist_t hist_q [AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				hist_q[i] <= '0;
			end
		end else if (wr.en) begin
			hist_q[wr_idx] <= wr.data;
		end
	end

	assign rd = hist_q[rd_idx];

endmodule
`default_nettype wire

// ===== hw/rtl/tif_chk.sv =====
`default_nettype none
module tif_chk import tif_pkg::*; #(
	parameter int AXES = AXES_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	tif_in_if.sink    sample,
	tif_out_if.source result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=>
			result.valid && $stable(result.displacement) &&
			$stable(result.out_axis) && $stable(result.divide_error))
		else $error("result beat changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.divide_error |-> result.displacement == '0)
		else $error("divide error with nonzero displacement");

	a_bad_axis: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (32'(result.out_axis) >= AXES) |->
			result.displacement == '0 && !result.divide_error)
		else $error("out-of-range axis gave a nonzero result");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> !sample.ready)
		else $error("second beat taken while an item is in flight");

endmodule

bind tustin_impedance_filter tif_chk #(.AXES(AXES)) u_tif_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.sample (sample),
	.result (result)
);
`default_nettype wire
